// File: hdl/rpn_stack_evaluator_assert.svh
// Assertion macros for the RPN stack evaluator.
// Depends on clk and rst_n being in scope where the macros are used.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define RPN_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn_stack_evaluator: same-cycle check failed");

// Check cons in the cycle after ante.
`define RPN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn_stack_evaluator: next-cycle check failed");

`endif

// File: hdl/rpn_pkg.sv
// Package for the RPN stack evaluator: sizes, command and status codes,
// sequencer states and the input and result word types. No dependencies.
package rpn_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_W      = 32;
    localparam int CMD_W       = 3;
    localparam int DEPTH_W     = 5;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(WORD_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FETCH,
        S_DIV,
        S_FIX,
        S_WRITE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [WORD_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        status_t                  status;
    } result_t;

endpackage

// File: hdl/rpn_stack_evaluator.sv
// RPN stack evaluator top level: operand stack memory, sequencer, shared ALU
// and radix-2 divider. Depends on rpn_pkg and rpn_stack_evaluator_assert.svh.
//
// Usage:
//   Input channel: drive item (command, value) and raise start; the word is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high until the result has been shown.
//   Result channel: result (top_value, depth, status) is valid for exactly
//   one cycle while done is high. The receiver cannot stall; it must take
//   the word in that cycle.
//   Sequence from the accepting edge: push, unknown commands and underflow
//   pass dispatch and response; add, subtract and multiply pass dispatch,
//   fetch, write and response; divide adds the divider steps and a sign
//   fix before write, and divide by zero goes from fetch to response.
//   Divide time is set by the 32-step radix-2 restoring divider, one quotient
//   bit per cycle; the others by the stack's single registered read port.
//   Reset (rst_n low, asynchronous) empties the stack and returns to idle;
//   stack contents are not cleared and no clearing pass is needed, since only
//   entries below the count are read.
`include "rpn_stack_evaluator_assert.svh"

module rpn_stack_evaluator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  rpn_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output rpn_pkg::result_t result
);

    rpn_pkg::state_t                  state_reg, state_next;
    logic [rpn_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [rpn_pkg::WORD_W-1:0]       val_reg, val_next;
    logic [rpn_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [rpn_pkg::WORD_W-1:0]       top_reg, top_next;
    logic [rpn_pkg::WORD_W-1:0]       res_reg, res_next;
    rpn_pkg::status_t                 status_reg, status_next;
    logic [rpn_pkg::WORD_W-1:0]       rem_reg, rem_next;
    logic [rpn_pkg::WORD_W-1:0]       quo_reg, quo_next;
    logic [rpn_pkg::WORD_W-1:0]       dvs_reg, dvs_next;
    logic                             neg_reg, neg_next;
    logic [rpn_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [rpn_pkg::WORD_W-1:0]       rd_data_reg;

    logic [rpn_pkg::WORD_W-1:0]       mem [rpn_pkg::STACK_DEPTH];

    logic                             accept;
    logic [rpn_pkg::CNT_W-1:0]        below_cnt;
    logic [rpn_pkg::ADDR_W-1:0]       rd_addr;
    logic                             wr_en;
    logic [rpn_pkg::ADDR_W-1:0]       wr_addr;
    logic [rpn_pkg::WORD_W-1:0]       wr_data;
    logic [rpn_pkg::WORD_W-1:0]       opa;
    logic [rpn_pkg::WORD_W-1:0]       opb;
    logic [rpn_pkg::WORD_W-1:0]       prod_lo;
    logic [rpn_pkg::WORD_W:0]         shifted;
    logic [rpn_pkg::WORD_W:0]         trial;
    logic                             is_full;
    logic                             is_short;

    assign busy      = (state_reg != rpn_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign below_cnt = count_reg - rpn_pkg::CNT_W'(2);
    assign rd_addr   = below_cnt[rpn_pkg::ADDR_W-1:0];
    assign opa       = top_reg;
    assign opb       = rd_data_reg;
    assign prod_lo   = opb * opa;
    assign shifted   = {rem_reg, quo_reg[rpn_pkg::WORD_W-1]};
    assign trial     = shifted - {1'b0, dvs_reg};
    assign is_full   = (count_reg >= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH));
    assign is_short  = (count_reg < rpn_pkg::CNT_W'(2));

    // Operand stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::S_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        top_reg    <= top_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        neg_reg    <= neg_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = rpn_pkg::S_DISPATCH;
                end
            end
            rpn_pkg::S_DISPATCH:
            begin
                if (cmd_reg inside {rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB,
                                    rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV} && !is_short)
                begin
                    state_next = rpn_pkg::S_FETCH;
                end
                else
                begin
                    state_next = rpn_pkg::S_RESP;
                end
            end
            rpn_pkg::S_FETCH:
            begin
                if (cmd_reg == rpn_pkg::CMD_DIV)
                begin
                    state_next = (opa == '0) ? rpn_pkg::S_RESP : rpn_pkg::S_DIV;
                end
                else
                begin
                    state_next = rpn_pkg::S_WRITE;
                end
            end
            rpn_pkg::S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = rpn_pkg::S_FIX;
                end
            end
            rpn_pkg::S_FIX:   state_next = rpn_pkg::S_WRITE;
            rpn_pkg::S_WRITE: state_next = rpn_pkg::S_RESP;
            rpn_pkg::S_RESP:  state_next = rpn_pkg::S_IDLE;
            default:          state_next = rpn_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        res_next    = res_reg;
        status_next = status_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        wr_en       = 1'b0;
        wr_addr     = rd_addr;
        wr_data     = res_reg;
        done        = 1'b0;

        case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = item.command;
                    val_next    = item.value;
                    status_next = rpn_pkg::ST_OK;
                end
            end
            rpn_pkg::S_DISPATCH:
            begin
                case (cmd_reg)
                    rpn_pkg::CMD_PUSH:
                    begin
                        if (is_full)
                        begin
                            status_next = rpn_pkg::ST_OVER;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[rpn_pkg::ADDR_W-1:0];
                            wr_data    = val_reg;
                            top_next   = val_reg;
                            count_next = count_reg + rpn_pkg::CNT_W'(1);
                        end
                    end
                    rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV:
                    begin
                        if (is_short)
                        begin
                            status_next = rpn_pkg::ST_UNDER;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            rpn_pkg::S_FETCH:
            begin
                case (cmd_reg)
                    rpn_pkg::CMD_ADD: res_next = opb + opa;
                    rpn_pkg::CMD_SUB: res_next = opb - opa;
                    rpn_pkg::CMD_MUL: res_next = prod_lo;
                    rpn_pkg::CMD_DIV:
                    begin
                        if (opa == '0)
                        begin
                            status_next = rpn_pkg::ST_DIVZ;
                        end
                        else
                        begin
                            rem_next  = '0;
                            quo_next  = opb[rpn_pkg::WORD_W-1] ? (~opb + 1'b1) : opb;
                            dvs_next  = opa[rpn_pkg::WORD_W-1] ? (~opa + 1'b1) : opa;
                            neg_next  = opa[rpn_pkg::WORD_W-1] ^ opb[rpn_pkg::WORD_W-1];
                            step_next = rpn_pkg::STEP_W'(rpn_pkg::WORD_W - 1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            rpn_pkg::S_DIV:
            begin
                // one restoring step per cycle
                if (trial[rpn_pkg::WORD_W])
                begin
                    rem_next = shifted[rpn_pkg::WORD_W-1:0];
                end
                else
                begin
                    rem_next = trial[rpn_pkg::WORD_W-1:0];
                end
                quo_next  = {quo_reg[rpn_pkg::WORD_W-2:0], ~trial[rpn_pkg::WORD_W]};
                step_next = step_reg - rpn_pkg::STEP_W'(1);
            end
            rpn_pkg::S_FIX:
            begin
                res_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            rpn_pkg::S_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = rd_addr;
                wr_data    = res_reg;
                top_next   = res_reg;
                count_next = count_reg - rpn_pkg::CNT_W'(1);
            end
            rpn_pkg::S_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.top_value = (count_reg == '0) ? '0 : top_reg;
        result.depth     = rpn_pkg::DEPTH_W'(count_reg);
        result.status    = status_reg;
    end

    `RPN_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
    `RPN_ASSERT_IMPL(a_done_busy, done, busy)
    `RPN_ASSERT_NEXT(a_accept_busy, accept, busy && !done)
    `RPN_ASSERT_NEXT(a_done_idle, done, !busy && !done)
    `RPN_ASSERT_NEXT(a_write_pop, state_reg == rpn_pkg::S_WRITE,
                     count_reg == $past(count_reg) - rpn_pkg::CNT_W'(1))

endmodule
